### rtl/assert_macros.svh
// Assertion macros of the checker file of the coprocessor block.
// Depends on nothing; included by the checker by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/scmpu_pkg.sv
// Constants, register codes and region match functions of the coprocessor block.
// Depends on nothing; used by the top level by scoped names.
package scmpu_pkg;

    localparam int REGION_COUNT = 8;
    localparam int RegionIdxW   = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

    // Word modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    // Access kinds of a check
    localparam logic [2:0] KIND_WRITE_USER = 3'd0;
    localparam logic [2:0] KIND_WRITE_SYS  = 3'd1;
    localparam logic [2:0] KIND_READ_USER  = 3'd2;
    localparam logic [2:0] KIND_READ_SYS   = 3'd3;
    localparam logic [2:0] KIND_EXEC_USER  = 3'd4;
    localparam logic [2:0] KIND_EXEC_SYS   = 3'd5;

    // Primary register numbers (CRn)
    localparam logic [3:0] CRN_ID        = 4'd0;
    localparam logic [3:0] CRN_CONTROL   = 4'd1;
    localparam logic [3:0] CRN_CACHE_CFG = 4'd2;
    localparam logic [3:0] CRN_WBUF      = 4'd3;
    localparam logic [3:0] CRN_PERM      = 4'd5;
    localparam logic [3:0] CRN_REGION    = 4'd6;
    localparam logic [3:0] CRN_CACHE_OP  = 4'd7;
    localparam logic [3:0] CRN_LOCK_TCM  = 4'd9;

    // Secondary selectors (CRm, opcode1, opcode2)
    localparam logic [3:0] CRM_BASE      = 4'd0;
    localparam logic [3:0] CRM_TCM       = 4'd1;
    localparam logic [2:0] OP2_MAIN      = 3'd0;
    localparam logic [2:0] OP2_ALT       = 3'd1;
    localparam logic [2:0] OP2_TCM_SIZE  = 3'd2;
    localparam logic [2:0] OP2_DATA_PERM = 3'd2;
    localparam logic [2:0] OP2_INST_PERM = 3'd3;
    localparam logic [2:0] OP2_WFI       = 3'd4;
    localparam logic [2:0] OP1_NONE      = 3'd0;

    localparam logic [31:0] ID_CODE     = 32'h4105_9461;
    localparam logic [31:0] CACHE_TYPE  = 32'h0F0D_2112;
    localparam logic [31:0] TCM_SIZE    = 32'h0014_0180;
    localparam logic [31:0] CTRL_RESET  = 32'h0001_2078;
    localparam logic [31:0] CTRL_WMASK  = 32'h000F_F085;
    localparam logic [31:0] CTRL_FIXED  = 32'h0000_0078;
    localparam logic [31:0] DTCM_WMASK  = 32'h0FFF_F000;
    localparam logic [31:0] PERM_RESET  = 32'h2222_2222;
    localparam logic [31:0] DTCM_RESET  = 32'h0080_000A;
    localparam logic [31:0] ITCM_RESET  = 32'h0000_000C;
    localparam logic [4:0]  SIZE_ALL    = 5'h1F;
    localparam int          MIN_GRAIN   = 6;

    // Enabled region holds the address: compare bits at and above max(size+1, 6).
    function automatic logic region_hit(input logic [31:0] rgn, input logic [31:0] addr);
        logic [4:0]  sz;
        logic [31:0] keep;
        sz = rgn[5:1];
        for (int b = 0; b < 32; b++)
        begin
            keep[b] = (b >= MIN_GRAIN) && (b > int'(sz));
        end
        return rgn[0] && ((sz == SIZE_ALL) || ((addr & keep) == (rgn & keep)));
    endfunction

    function automatic logic nibble_grants(input logic [3:0] nib, input logic [2:0] kind);
        logic g;
        case (kind)
            KIND_WRITE_USER: g = (nib == 4'd3);
            KIND_WRITE_SYS:  g = (nib >= 4'd1) && (nib <= 4'd3);
            KIND_READ_USER:  g = (nib == 4'd2) || (nib == 4'd3) || (nib == 4'd6);
            KIND_READ_SYS:   g = ((nib >= 4'd1) && (nib <= 4'd3)) || (nib == 4'd5)
                                 || (nib == 4'd6);
            KIND_EXEC_USER:  g = (nib == 4'd2) || (nib == 4'd3) || (nib == 4'd6);
            KIND_EXEC_SYS:   g = ((nib >= 4'd1) && (nib <= 4'd3)) || (nib == 4'd6);
            default:         g = 1'b0;
        endcase
        return g;
    endfunction

endpackage

### rtl/system_coprocessor_with_mpu.sv
// System control coprocessor with an eight-region protection unit.
// Depends on scmpu_pkg (constants, region match and permission functions).
//
// Each request word is a register read, a register write or an access check,
// and yields exactly one response word. A word taken on req_valid && !req_stall
// lands in an input register; once the output slot is empty or draining, the
// decode, the region compares (all regions side by side) and any register
// update happen in one pass, and the response is loaded into the output
// register, which drives rsp_valid; a full output slot under rsp_stall holds
// the word in the input register. One word is taken every cycle as
// long as the response side keeps draining; the register file is updated as
// a word leaves the input register, so the next word always sees the result
// of the one before. The status outputs (high_vectors, thumb_load_enable,
// big_endian_mode, dtcm_base_reg) reflect the registers after the word's
// own write. Register access in user mode, unknown selections and region
// numbers past the region count are refused with accepted low.
module system_coprocessor_with_mpu
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  mode,
    input  logic        user_mode,
    input  logic [3:0]  reg_major,
    input  logic [3:0]  reg_minor,
    input  logic [2:0]  op_first,
    input  logic [2:0]  op_second,
    input  logic [31:0] write_value,
    input  logic [31:0] address,
    input  logic [2:0]  access_kind,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        accepted,
    output logic [31:0] read_data,
    output logic        allowed,
    output logic        wait_irq,
    output logic        high_vectors,
    output logic        thumb_load_enable,
    output logic        big_endian_mode,
    output logic [27:0] dtcm_base_reg
);

    localparam int NR = scmpu_pkg::REGION_COUNT;
    localparam int IW = scmpu_pkg::RegionIdxW;

    // Input register
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  mode_reg;
    logic        user_reg;
    logic [3:0]  crn_reg;
    logic [3:0]  crm_reg;
    logic [2:0]  op1_reg;
    logic [2:0]  op2_reg;
    logic [31:0] wval_reg;
    logic [31:0] addr_reg;
    logic [2:0]  kind_reg;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        acc_reg, acc_next;
    logic [31:0] rd_reg, rd_next;
    logic        allow_reg, allow_next;
    logic        wfi_reg, wfi_next;
    logic        hv_reg, hv_next;
    logic        tle_reg, tle_next;
    logic        be_reg, be_next;
    logic [27:0] dtcm_out_reg, dtcm_out_next;

    // Coprocessor registers
    logic [31:0] ctrl_reg, ctrl_next;
    logic [31:0] dcfg_reg, dcfg_next;
    logic [31:0] icfg_reg, icfg_next;
    logic [31:0] wbuf_reg, wbuf_next;
    logic [31:0] dperm_reg, dperm_next;
    logic [31:0] iperm_reg, iperm_next;
    logic [31:0] region_reg [NR];
    logic [31:0] region_next [NR];
    logic [31:0] dlock_reg, dlock_next;
    logic [31:0] ilock_reg, ilock_next;
    logic [31:0] dtcm_reg, dtcm_next;
    logic [31:0] itcm_reg, itcm_next;

    logic        take_in;
    logic        advance;
    logic        is_read;
    logic        is_write;
    logic        rd_ok;
    logic [31:0] rd_val;
    logic        wr_ok;
    logic        wfi_hit;
    logic        crm_in_range;
    logic [IW-1:0] rgn_idx;
    logic [31:0] perm_sel;
    logic [NR-1:0] grant;
    logic        check_ok;

    // Handshake: move the word on whenever the output slot is empty or draining.
    assign advance   = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign take_in   = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
    end

    assign is_read      = (mode_reg == scmpu_pkg::MODE_READ) && !user_reg;
    assign is_write     = (mode_reg == scmpu_pkg::MODE_WRITE) && !user_reg;
    assign crm_in_range = int'(crm_reg) < NR;
    assign rgn_idx      = crm_reg[IW-1:0];

    // Register read decode
    always_comb
    begin
        rd_ok  = 1'b0;
        rd_val = '0;
        if (op1_reg == scmpu_pkg::OP1_NONE)
        begin
            case (crn_reg)
                scmpu_pkg::CRN_ID:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE)
                    begin
                        rd_ok = 1'b1;
                        if (op2_reg == scmpu_pkg::OP2_ALT)
                            rd_val = scmpu_pkg::CACHE_TYPE;
                        else if (op2_reg == scmpu_pkg::OP2_TCM_SIZE)
                            rd_val = scmpu_pkg::TCM_SIZE;
                        else
                            rd_val = scmpu_pkg::ID_CODE;
                    end
                end
                scmpu_pkg::CRN_CONTROL:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = ctrl_reg;
                    end
                end
                scmpu_pkg::CRN_CACHE_CFG:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = dcfg_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_ALT)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = icfg_reg;
                    end
                end
                scmpu_pkg::CRN_WBUF:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = wbuf_reg;
                    end
                end
                scmpu_pkg::CRN_PERM:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE
                        && op2_reg == scmpu_pkg::OP2_DATA_PERM)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = dperm_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_BASE
                             && op2_reg == scmpu_pkg::OP2_INST_PERM)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = iperm_reg;
                    end
                end
                scmpu_pkg::CRN_REGION:
                begin
                    if (op2_reg == scmpu_pkg::OP2_MAIN && crm_in_range)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = region_reg[rgn_idx];
                    end
                end
                scmpu_pkg::CRN_LOCK_TCM:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = dlock_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_BASE
                             && op2_reg == scmpu_pkg::OP2_ALT)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = ilock_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_TCM
                             && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = dtcm_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_TCM
                             && op2_reg == scmpu_pkg::OP2_ALT)
                    begin
                        rd_ok  = 1'b1;
                        rd_val = itcm_reg;
                    end
                end
                default:
                begin
                    rd_ok = 1'b0;
                end
            endcase
        end
    end

    // Register write decode and next register values
    always_comb
    begin
        ctrl_next  = ctrl_reg;
        dcfg_next  = dcfg_reg;
        icfg_next  = icfg_reg;
        wbuf_next  = wbuf_reg;
        dperm_next = dperm_reg;
        iperm_next = iperm_reg;
        dlock_next = dlock_reg;
        ilock_next = ilock_reg;
        dtcm_next  = dtcm_reg;
        itcm_next  = itcm_reg;
        for (int r = 0; r < NR; r++)
        begin
            region_next[r] = region_reg[r];
        end
        wr_ok   = 1'b0;
        wfi_hit = 1'b0;

        if (is_write && advance && op1_reg == scmpu_pkg::OP1_NONE)
        begin
            case (crn_reg)
                scmpu_pkg::CRN_CONTROL:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        wr_ok     = 1'b1;
                        ctrl_next = (wval_reg & scmpu_pkg::CTRL_WMASK)
                                    | scmpu_pkg::CTRL_FIXED;
                    end
                end
                scmpu_pkg::CRN_CACHE_CFG:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        wr_ok     = 1'b1;
                        dcfg_next = wval_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_ALT)
                    begin
                        wr_ok     = 1'b1;
                        icfg_next = wval_reg;
                    end
                end
                scmpu_pkg::CRN_WBUF:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        wr_ok     = 1'b1;
                        wbuf_next = wval_reg;
                    end
                end
                scmpu_pkg::CRN_PERM:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE
                        && op2_reg == scmpu_pkg::OP2_DATA_PERM)
                    begin
                        wr_ok      = 1'b1;
                        dperm_next = wval_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_BASE
                             && op2_reg == scmpu_pkg::OP2_INST_PERM)
                    begin
                        wr_ok      = 1'b1;
                        iperm_next = wval_reg;
                    end
                end
                scmpu_pkg::CRN_REGION:
                begin
                    if (op2_reg == scmpu_pkg::OP2_MAIN && crm_in_range)
                    begin
                        wr_ok                = 1'b1;
                        region_next[rgn_idx] = wval_reg;
                    end
                end
                scmpu_pkg::CRN_CACHE_OP:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_WFI)
                    begin
                        wr_ok   = 1'b1;
                        wfi_hit = 1'b1;
                    end
                end
                scmpu_pkg::CRN_LOCK_TCM:
                begin
                    if (crm_reg == scmpu_pkg::CRM_BASE && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        wr_ok      = 1'b1;
                        dlock_next = wval_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_BASE
                             && op2_reg == scmpu_pkg::OP2_ALT)
                    begin
                        wr_ok      = 1'b1;
                        ilock_next = wval_reg;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_TCM
                             && op2_reg == scmpu_pkg::OP2_MAIN)
                    begin
                        wr_ok     = 1'b1;
                        dtcm_next = wval_reg & scmpu_pkg::DTCM_WMASK;
                    end
                    else if (crm_reg == scmpu_pkg::CRM_TCM
                             && op2_reg == scmpu_pkg::OP2_ALT)
                    begin
                        wr_ok     = 1'b1;
                        itcm_next = wval_reg;
                    end
                end
                default:
                begin
                    wr_ok = 1'b0;
                end
            endcase
        end
    end

    // Access check: regions compare in parallel; a grant or ctrl[0] low passes.
    assign perm_sel = (kind_reg >= scmpu_pkg::KIND_EXEC_USER) ? iperm_reg : dperm_reg;

    always_comb
    begin
        for (int r = 0; r < NR; r++)
        begin
            grant[r] = scmpu_pkg::region_hit(region_reg[r], addr_reg)
                       && scmpu_pkg::nibble_grants(perm_sel[4*r +: 4], kind_reg);
        end
    end

    assign check_ok = !ctrl_reg[0] || (|grant);

    // Response word
    always_comb
    begin
        acc_next      = (is_read && rd_ok) || (is_write && wr_ok);
        rd_next       = (is_read && rd_ok) ? rd_val : '0;
        allow_next    = (mode_reg == scmpu_pkg::MODE_CHECK) && check_ok;
        wfi_next      = is_write && wfi_hit;
        hv_next       = ctrl_next[13];
        tle_next      = !ctrl_next[15];
        be_next       = ctrl_next[7];
        dtcm_out_next = dtcm_next[27:0];
    end

    // Control and coprocessor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= scmpu_pkg::CTRL_RESET;
            dcfg_reg      <= '0;
            icfg_reg      <= '0;
            wbuf_reg      <= '0;
            dperm_reg     <= scmpu_pkg::PERM_RESET;
            iperm_reg     <= scmpu_pkg::PERM_RESET;
            dlock_reg     <= '0;
            ilock_reg     <= '0;
            dtcm_reg      <= scmpu_pkg::DTCM_RESET;
            itcm_reg      <= scmpu_pkg::ITCM_RESET;
            for (int r = 0; r < NR; r++)
            begin
                region_reg[r] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            ctrl_reg      <= ctrl_next;
            dcfg_reg      <= dcfg_next;
            icfg_reg      <= icfg_next;
            wbuf_reg      <= wbuf_next;
            dperm_reg     <= dperm_next;
            iperm_reg     <= iperm_next;
            dlock_reg     <= dlock_next;
            ilock_reg     <= ilock_next;
            dtcm_reg      <= dtcm_next;
            itcm_reg      <= itcm_next;
            for (int r = 0; r < NR; r++)
            begin
                region_reg[r] <= region_next[r];
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            mode_reg <= mode;
            user_reg <= user_mode;
            crn_reg  <= reg_major;
            crm_reg  <= reg_minor;
            op1_reg  <= op_first;
            op2_reg  <= op_second;
            wval_reg <= write_value;
            addr_reg <= address;
            kind_reg <= access_kind;
        end
        if (advance)
        begin
            acc_reg      <= acc_next;
            rd_reg       <= rd_next;
            allow_reg    <= allow_next;
            wfi_reg      <= wfi_next;
            hv_reg       <= hv_next;
            tle_reg      <= tle_next;
            be_reg       <= be_next;
            dtcm_out_reg <= dtcm_out_next;
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign accepted          = acc_reg;
    assign read_data         = rd_reg;
    assign allowed           = allow_reg;
    assign wait_irq          = wfi_reg;
    assign high_vectors      = hv_reg;
    assign thumb_load_enable = tle_reg;
    assign big_endian_mode   = be_reg;
    assign dtcm_base_reg     = dtcm_out_reg;

endmodule

### rtl/scmpu_checker.sv
// Port-level checks of the coprocessor block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module scmpu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic        accepted,
    input logic [31:0] read_data,
    input logic        allowed,
    input logic        wait_irq
);

    // A waiting response word stays offered.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)

    // Nonzero read data comes only from a performed read.
    `ASSERT_IMPLIES(a_data_needs_acc, clk, rst_n, rsp_valid && (read_data != 32'd0), accepted)

    // A wait request is a performed write: no data, no check result.
    `ASSERT_IMPLIES(a_wfi_is_write, clk, rst_n, rsp_valid && wait_irq,
        accepted && (read_data == 32'd0) && !allowed)

    // A check result never comes with a register operation.
    `ASSERT_IMPLIES(a_allow_only_check, clk, rst_n, rsp_valid && allowed, !accepted)

endmodule

bind system_coprocessor_with_mpu scmpu_checker u_scmpu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .accepted  (accepted),
    .read_data (read_data),
    .allowed   (allowed),
    .wait_irq  (wait_irq)
);

### sim/tb.sv
// Self-checking testbench for system_coprocessor_with_mpu: register reads and writes
// and access checks are driven in, and every response word is compared with a predictor.
// Depends on rtl/scmpu_pkg.sv and rtl/system_coprocessor_with_mpu.sv.
`timescale 1ns / 100ps

module tb;

    import scmpu_pkg::*;

    // Codes that the package leaves out but the fields can still carry
    localparam logic [1:0] MODE_IDLE     = 2'd3;
    localparam logic [2:0] KIND_UNUSED_A = 3'd6;
    localparam logic [2:0] KIND_UNUSED_B = 3'd7;
    localparam logic [3:0] CRN_UNMAPPED  = 4'd4;
    localparam logic [3:0] CRM_TOP       = 4'd15;
    localparam logic [2:0] OP1_TOP       = 3'd7;
    localparam logic [2:0] OP2_TOP       = 3'd7;

    localparam int RANDOM_WORDS  = 1100;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 150;
    localparam int STEADY_FROM   = 600;
    localparam int STEADY_TO     = 800;
    localparam int IDLE_PERCENT  = 33;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [1:0]  mode;
        logic        user_mode;
        logic [3:0]  crn;
        logic [3:0]  crm;
        logic [2:0]  op1;
        logic [2:0]  op2;
        logic [31:0] wval;
        logic [31:0] addr;
        logic [2:0]  kind;
    } cp_request_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] read_data;
        logic        allowed;
        logic        wait_irq;
        logic        high_vectors;
        logic        thumb_load_enable;
        logic        big_endian_mode;
        logic [27:0] dtcm_base_reg;
    } cp_response_t;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Request channel, held at known values from time 0
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  mode = '0;
    logic        user_mode = 1'b0;
    logic [3:0]  reg_major = '0;
    logic [3:0]  reg_minor = '0;
    logic [2:0]  op_first = '0;
    logic [2:0]  op_second = '0;
    logic [31:0] write_value = '0;
    logic [31:0] address = '0;
    logic [2:0]  access_kind = '0;

    // Response channel
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic        accepted;
    logic [31:0] read_data;
    logic        allowed;
    logic        wait_irq;
    logic        high_vectors;
    logic        thumb_load_enable;
    logic        big_endian_mode;
    logic [27:0] dtcm_base_reg;

    system_coprocessor_with_mpu u_top
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .mode              (mode),
        .user_mode         (user_mode),
        .reg_major         (reg_major),
        .reg_minor         (reg_minor),
        .op_first          (op_first),
        .op_second         (op_second),
        .write_value       (write_value),
        .address           (address),
        .access_kind       (access_kind),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .accepted          (accepted),
        .read_data         (read_data),
        .allowed           (allowed),
        .wait_irq          (wait_irq),
        .high_vectors      (high_vectors),
        .thumb_load_enable (thumb_load_enable),
        .big_endian_mode   (big_endian_mode),
        .dtcm_base_reg     (dtcm_base_reg)
    );

    // Words waiting to be offered, and responses the block still owes
    cp_request_t  pending_requests[$];
    cp_response_t expected_responses[$];

    cp_request_t  offered_word;
    int           words_sent;
    int           words_received;
    int           mismatch_count = 0;
    int           hold_left;
    bit           hold_done;
    logic [31:0]  gen_region[REGION_COUNT];

    // Predictor's own copy of the coprocessor registers
    logic [31:0] m_control;
    logic [31:0] m_dcache_cfg;
    logic [31:0] m_icache_cfg;
    logic [31:0] m_wbuf;
    logic [31:0] m_dperm;
    logic [31:0] m_iperm;
    logic [31:0] m_region[REGION_COUNT];
    logic [31:0] m_dlock;
    logic [31:0] m_ilock;
    logic [31:0] m_dtcm;
    logic [31:0] m_itcm;

    task automatic reset_registers();
        m_control    = CTRL_RESET;
        m_dcache_cfg = '0;
        m_icache_cfg = '0;
        m_wbuf       = '0;
        m_dperm      = PERM_RESET;
        m_iperm      = PERM_RESET;
        m_dlock      = '0;
        m_ilock      = '0;
        m_dtcm       = DTCM_RESET;
        m_itcm       = ITCM_RESET;
        for (int r = 0; r < REGION_COUNT; r++)
        begin
            m_region[r] = '0;
        end
    endtask

    // An enabled region holds the address when all bits above its span agree;
    // the span never drops below 64 bytes, and the largest size code covers all.
    function automatic logic region_covers(input logic [31:0] rgn, input logic [31:0] a);
        logic [4:0]  sz;
        logic [31:0] span;
        logic        hit;
        sz   = rgn[5:1];
        span = ((32'd1 << ({27'd0, sz} + 32'd1)) - 32'd1) | ((32'd1 << MIN_GRAIN) - 32'd1);
        hit  = rgn[0] && ((sz == SIZE_ALL) || (((a ^ rgn) & ~span) == '0));
        return hit;
    endfunction

    // Set of permission nibble values that grant each access kind
    function automatic logic access_permitted(input logic [31:0] a, input logic [2:0] kind);
        logic [31:0] perms;
        logic [15:0] grant_set;
        logic        ok;
        case (kind)
            KIND_WRITE_USER: grant_set = 16'h0008;
            KIND_WRITE_SYS:  grant_set = 16'h000E;
            KIND_READ_USER:  grant_set = 16'h004C;
            KIND_READ_SYS:   grant_set = 16'h006E;
            KIND_EXEC_USER:  grant_set = 16'h004C;
            KIND_EXEC_SYS:   grant_set = 16'h004E;
            default:         grant_set = 16'h0000;
        endcase
        perms = (kind >= KIND_EXEC_USER) ? m_iperm : m_dperm;
        ok    = !m_control[0];
        for (int r = 0; r < REGION_COUNT; r++)
        begin
            if (region_covers(m_region[r], a) && grant_set[perms[4*r +: 4]])
            begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

    task automatic read_register(input cp_request_t q, output logic ok, output logic [31:0] v);
        ok = 1'b0;
        v  = '0;
        if (q.op1 == OP1_NONE)
        begin
            case (q.crn)
                CRN_ID:
                begin
                    ok = (q.crm == CRM_BASE);
                    v  = (q.op2 == OP2_ALT) ? CACHE_TYPE :
                         (q.op2 == OP2_TCM_SIZE) ? TCM_SIZE : ID_CODE;
                end
                CRN_CONTROL:
                begin
                    ok = (q.crm == CRM_BASE) && (q.op2 == OP2_MAIN);
                    v  = m_control;
                end
                CRN_CACHE_CFG:
                begin
                    ok = (q.crm == CRM_BASE) && ((q.op2 == OP2_MAIN) || (q.op2 == OP2_ALT));
                    v  = (q.op2 == OP2_MAIN) ? m_dcache_cfg : m_icache_cfg;
                end
                CRN_WBUF:
                begin
                    ok = (q.crm == CRM_BASE) && (q.op2 == OP2_MAIN);
                    v  = m_wbuf;
                end
                CRN_PERM:
                begin
                    ok = (q.crm == CRM_BASE)
                         && ((q.op2 == OP2_DATA_PERM) || (q.op2 == OP2_INST_PERM));
                    v  = (q.op2 == OP2_DATA_PERM) ? m_dperm : m_iperm;
                end
                CRN_REGION:
                begin
                    ok = (q.op2 == OP2_MAIN) && (q.crm < REGION_COUNT);
                    v  = m_region[q.crm[2:0]];
                end
                CRN_LOCK_TCM:
                begin
                    ok = ((q.crm == CRM_BASE) || (q.crm == CRM_TCM))
                         && ((q.op2 == OP2_MAIN) || (q.op2 == OP2_ALT));
                    if (q.crm == CRM_BASE)
                    begin
                        v = (q.op2 == OP2_MAIN) ? m_dlock : m_ilock;
                    end
                    else
                    begin
                        v = (q.op2 == OP2_MAIN) ? m_dtcm : m_itcm;
                    end
                end
                default: ok = 1'b0;
            endcase
        end
        if (!ok)
        begin
            v = '0;
        end
    endtask

    task automatic write_register(input cp_request_t q, output logic ok, output logic wfi);
        ok  = 1'b0;
        wfi = 1'b0;
        if (q.op1 == OP1_NONE)
        begin
            case (q.crn)
                CRN_CONTROL:
                begin
                    if ((q.crm == CRM_BASE) && (q.op2 == OP2_MAIN))
                    begin
                        m_control = (q.wval & CTRL_WMASK) | CTRL_FIXED;
                        ok = 1'b1;
                    end
                end
                CRN_CACHE_CFG:
                begin
                    if ((q.crm == CRM_BASE) && (q.op2 == OP2_MAIN))
                    begin
                        m_dcache_cfg = q.wval;
                        ok = 1'b1;
                    end
                    else if ((q.crm == CRM_BASE) && (q.op2 == OP2_ALT))
                    begin
                        m_icache_cfg = q.wval;
                        ok = 1'b1;
                    end
                end
                CRN_WBUF:
                begin
                    if ((q.crm == CRM_BASE) && (q.op2 == OP2_MAIN))
                    begin
                        m_wbuf = q.wval;
                        ok = 1'b1;
                    end
                end
                CRN_PERM:
                begin
                    if ((q.crm == CRM_BASE) && (q.op2 == OP2_DATA_PERM))
                    begin
                        m_dperm = q.wval;
                        ok = 1'b1;
                    end
                    else if ((q.crm == CRM_BASE) && (q.op2 == OP2_INST_PERM))
                    begin
                        m_iperm = q.wval;
                        ok = 1'b1;
                    end
                end
                CRN_REGION:
                begin
                    if ((q.op2 == OP2_MAIN) && (q.crm < REGION_COUNT))
                    begin
                        m_region[q.crm[2:0]] = q.wval;
                        ok = 1'b1;
                    end
                end
                CRN_CACHE_OP:
                begin
                    ok  = (q.crm == CRM_BASE) && (q.op2 == OP2_WFI);
                    wfi = ok;
                end
                CRN_LOCK_TCM:
                begin
                    ok = ((q.crm == CRM_BASE) || (q.crm == CRM_TCM))
                         && ((q.op2 == OP2_MAIN) || (q.op2 == OP2_ALT));
                    if (ok && (q.crm == CRM_BASE) && (q.op2 == OP2_MAIN))
                    begin
                        m_dlock = q.wval;
                    end
                    else if (ok && (q.crm == CRM_BASE))
                    begin
                        m_ilock = q.wval;
                    end
                    else if (ok && (q.op2 == OP2_MAIN))
                    begin
                        m_dtcm = q.wval & DTCM_WMASK;
                    end
                    else if (ok)
                    begin
                        m_itcm = q.wval;
                    end
                end
                default: ok = 1'b0;
            endcase
        end
    endtask

    // Work out the response to one accepted word and apply its register update.
    // Status outputs follow the registers after this word's own write.
    task automatic compute_response(input cp_request_t q, output cp_response_t r);
        logic        ok;
        logic        wfi;
        logic [31:0] rd;
        ok  = 1'b0;
        wfi = 1'b0;
        rd  = '0;
        r   = '0;
        if ((q.mode == MODE_READ) && !q.user_mode)
        begin
            read_register(q, ok, rd);
        end
        else if ((q.mode == MODE_WRITE) && !q.user_mode)
        begin
            write_register(q, ok, wfi);
        end
        else if (q.mode == MODE_CHECK)
        begin
            r.allowed = access_permitted(q.addr, q.kind);
        end
        r.accepted          = ok;
        r.read_data         = rd;
        r.wait_irq          = ok && wfi;
        r.high_vectors      = m_control[13];
        r.thumb_load_enable = ~m_control[15];
        r.big_endian_mode   = m_control[7];
        r.dtcm_base_reg     = m_dtcm[27:0];
    endtask

    task automatic push_request(input logic [1:0] md, input logic usr, input logic [3:0] crn,
                                input logic [3:0] crm, input logic [2:0] op1,
                                input logic [2:0] op2, input logic [31:0] wv,
                                input logic [31:0] a, input logic [2:0] kind);
        cp_request_t w;
        w = '{md, usr, crn, crm, op1, op2, wv, a, kind};
        pending_requests.push_back(w);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("response %0d: %s expected %h, got %h",
                         words_received, fname, want, got);
            end
        end
    endtask

    // Sender: hold a word until it is taken, then maybe idle before the
    // next one. Valid never looks at stall, so a stalled word sits unchanged.
    // The predictor runs here, at the edge that takes the word.
    always @(posedge clk or negedge rst_n)
    begin : sender
        cp_response_t rsp;
        logic         next_valid;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            words_sent = 0;
            reset_registers();
        end
        else
        begin
            next_valid = req_valid;
            if (req_valid && !req_stall)
            begin
                compute_response(offered_word, rsp);
                expected_responses.push_back(rsp);
                words_sent++;
                next_valid = 1'b0;
            end
            // Offer the next word unless this cycle idles; no idling inside the
            // steady stretch.
            if (!next_valid && (pending_requests.size() > 0)
                && (((words_sent >= STEADY_FROM) && (words_sent < STEADY_TO))
                    || ($urandom_range(0, 99) >= IDLE_PERCENT)))
            begin
                offered_word = pending_requests.pop_front();
                next_valid   = 1'b1;
                mode        <= offered_word.mode;
                user_mode   <= offered_word.user_mode;
                reg_major   <= offered_word.crn;
                reg_minor   <= offered_word.crm;
                op_first    <= offered_word.op1;
                op_second   <= offered_word.op2;
                write_value <= offered_word.wval;
                address     <= offered_word.addr;
                access_kind <= offered_word.kind;
            end
            req_valid <= next_valid;
        end
    end

    // Receiver: compare each taken response with the oldest expectation, and
    // stall at random. Once, after a few hundred responses, hold off for a long
    // stretch so the block backs up and stalls its request side.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        cp_response_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            words_received = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("response %0d arrived with nothing expected", words_received);
                    end
                end
                else
                begin
                    want = expected_responses.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(accepted));
                    check_field("read_data", want.read_data, read_data);
                    check_field("allowed", 32'(want.allowed), 32'(allowed));
                    check_field("wait_irq", 32'(want.wait_irq), 32'(wait_irq));
                    check_field("high_vectors", 32'(want.high_vectors), 32'(high_vectors));
                    check_field("thumb_load_enable", 32'(want.thumb_load_enable),
                                32'(thumb_load_enable));
                    check_field("big_endian_mode", 32'(want.big_endian_mode),
                                32'(big_endian_mode));
                    check_field("dtcm_base_reg", 32'(want.dtcm_base_reg), 32'(dtcm_base_reg));
                end
                words_received++;
            end
            if (!hold_done && (words_received >= HOLD_AT))
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if ((words_received >= STEADY_FROM) && (words_received < STEADY_TO))
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        cp_request_t w;
        int          pick;
        int          sel;
        logic [4:0]  sz;
        logic [31:0] span;

        for (int r = 0; r < REGION_COUNT; r++)
        begin
            gen_region[r] = '0;
        end

        // Identification reads, including an opcode2 that falls back to the ID code
        push_request(MODE_READ, 1'b0, CRN_ID, CRM_BASE, OP1_NONE, OP2_MAIN, '0, '0, '0);
        push_request(MODE_READ, 1'b0, CRN_ID, CRM_BASE, OP1_NONE, OP2_ALT, '0, '0, '0);
        push_request(MODE_READ, 1'b0, CRN_ID, CRM_BASE, OP1_NONE, OP2_TCM_SIZE, '0, '0, '0);
        push_request(MODE_READ, 1'b0, CRN_ID, CRM_BASE, OP1_NONE, OP2_TOP, '0, '0, '0);
        push_request(MODE_READ, 1'b0, CRN_CONTROL, CRM_BASE, OP1_NONE, OP2_MAIN, '0, '0, '0);
        // Protection still off after reset: any access passes
        push_request(MODE_CHECK, 1'b1, '0, '0, '0, '0, '0, '1, KIND_WRITE_USER);
        // User mode register access is refused
        push_request(MODE_READ, 1'b1, CRN_CONTROL, CRM_BASE, OP1_NONE, OP2_MAIN, '0, '0, '0);
        push_request(MODE_WRITE, 1'b1, CRN_CONTROL, CRM_BASE, OP1_NONE, OP2_MAIN, '1, '0, '0);
        // Unknown selection
        push_request(MODE_READ, 1'b0, CRN_UNMAPPED, CRM_BASE, OP1_NONE, OP2_MAIN, '0, '0, '0);
        // Region 0 covers everything; region 7 covers the top 64 KB
        push_request(MODE_WRITE, 1'b0, CRN_REGION, 4'd0, OP1_NONE, OP2_MAIN,
                     32'h0000_003F, '0, '0);
        push_request(MODE_WRITE, 1'b0, CRN_REGION, 4'(REGION_COUNT - 1), OP1_NONE, OP2_MAIN,
                     32'hFFFF_001F, '0, '0);
        // Region numbers past the region count are refused
        push_request(MODE_WRITE, 1'b0, CRN_REGION, 4'(REGION_COUNT), OP1_NONE, OP2_MAIN,
                     '1, '0, '0);
        push_request(MODE_READ, 1'b0, CRN_REGION, CRM_TOP, OP1_NONE, OP2_MAIN, '0, '0, '0);
        push_request(MODE_WRITE, 1'b0, CRN_PERM, CRM_BASE, OP1_NONE, OP2_DATA_PERM,
                     32'h6000_0003, '0, '0);
        push_request(MODE_WRITE, 1'b0, CRN_PERM, CRM_BASE, OP1_NONE, OP2_INST_PERM,
                     32'h1000_0005, '0, '0);
        // All ones into control: protection on, every writable bit set
        push_request(MODE_WRITE, 1'b0, CRN_CONTROL, CRM_BASE, OP1_NONE, OP2_MAIN, '1, '0, '0);
        push_request(MODE_CHECK, 1'b0, '0, '0, '0, '0, '0, '0, KIND_WRITE_USER);
        push_request(MODE_CHECK, 1'b0, '0, '0, '0, '0, '0, 32'hFFFF_FFFC, KIND_READ_USER);
        push_request(MODE_CHECK, 1'b0, '0, '0, '0, '0, '0, '1, KIND_EXEC_SYS);
        // Unused access kind is denied while protection is on
        push_request(MODE_CHECK, 1'b0, '0, '0, '0, '0, '0, '0, KIND_UNUSED_B);
        push_request(MODE_WRITE, 1'b0, CRN_CACHE_OP, CRM_BASE, OP1_NONE, OP2_WFI, '0, '0, '0);
        // Nonzero opcode1 is refused
        push_request(MODE_WRITE, 1'b0, CRN_CONTROL, CRM_BASE, OP1_TOP, OP2_MAIN, '0, '0, '0);
        push_request(MODE_WRITE, 1'b0, CRN_LOCK_TCM, CRM_TCM, OP1_NONE, OP2_MAIN, '1, '0, '0);
        push_request(MODE_READ, 1'b0, CRN_LOCK_TCM, CRM_TCM, OP1_NONE, OP2_MAIN, '0, '0, '0);
        // Fourth mode does nothing at all
        push_request(MODE_IDLE, 1'b1, '1, '1, '1, '1, '1, '1, '1);
        // Protection off again: even an unused kind passes
        push_request(MODE_WRITE, 1'b0, CRN_CONTROL, CRM_BASE, OP1_NONE, OP2_MAIN, '0, '0, '0);
        push_request(MODE_CHECK, 1'b0, '0, '0, '0, '0, '0, '0, KIND_UNUSED_A);

        // Random words: mostly well-formed register traffic and checks aimed at
        // the programmed regions, with some raw noise on every field.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            w           = '0;
            pick        = $urandom_range(0, 99);
            w.user_mode = ($urandom_range(0, 19) == 0);
            w.wval      = $urandom;
            w.addr      = $urandom;
            w.kind      = 3'($urandom_range(KIND_WRITE_USER, KIND_EXEC_SYS));
            if (pick < 10)
            begin
                w.mode      = 2'($urandom);
                w.user_mode = 1'($urandom);
                w.crn       = 4'($urandom);
                w.crm       = 4'($urandom);
                w.op1       = 3'($urandom);
                w.op2       = 3'($urandom);
                w.kind      = 3'($urandom);
            end
            else if (pick < 45)
            begin
                w.mode = MODE_CHECK;
                sel    = $urandom_range(0, REGION_COUNT - 1);
                // Land inside a programmed region, sometimes just outside it
                if (($urandom_range(0, 2) != 0) && gen_region[sel][0])
                begin
                    sz   = gen_region[sel][5:1];
                    span = (sz == SIZE_ALL) ? '1 :
                           (((32'd1 << ({27'd0, sz} + 32'd1)) - 32'd1) | 32'h3F);
                    w.addr = (gen_region[sel] & ~span) | (w.addr & span);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        w.addr = w.addr ^ (32'd1 << $urandom_range(MIN_GRAIN, 31));
                    end
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    w.kind = 3'($urandom_range(KIND_UNUSED_A, KIND_UNUSED_B));
                end
            end
            else if (pick < 75)
            begin
                w.mode = MODE_WRITE;
                w.op1  = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(1, 7)) : OP1_NONE;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        w.crn       = CRN_REGION;
                        w.crm       = 4'($urandom_range(0, REGION_COUNT - 1));
                        w.wval[0]   = ($urandom_range(0, 9) != 0);
                        if (!w.user_mode && (w.op1 == OP1_NONE))
                        begin
                            gen_region[w.crm[2:0]] = w.wval;
                        end
                    end
                    4:
                    begin
                        w.crn = CRN_PERM;
                        w.op2 = $urandom_range(0, 1) ? OP2_DATA_PERM : OP2_INST_PERM;
                        // Keep nibbles mostly in the granting range
                        if ($urandom_range(0, 4) != 0)
                        begin
                            for (int n = 0; n < 8; n++)
                            begin
                                w.wval[4*n +: 4] = 4'($urandom_range(0, 7));
                            end
                        end
                    end
                    5:
                    begin
                        w.crn     = CRN_CONTROL;
                        w.wval[0] = ($urandom_range(0, 3) != 0);
                    end
                    6:
                    begin
                        w.crn = CRN_CACHE_CFG;
                        w.op2 = $urandom_range(0, 1) ? OP2_ALT : OP2_MAIN;
                    end
                    7:
                    begin
                        w.crn = $urandom_range(0, 1) ? CRN_WBUF : CRN_CACHE_OP;
                        w.op2 = (w.crn == CRN_CACHE_OP) ? OP2_WFI : OP2_MAIN;
                    end
                    8:
                    begin
                        w.crn = CRN_LOCK_TCM;
                        w.crm = $urandom_range(0, 1) ? CRM_TCM : CRM_BASE;
                        w.op2 = $urandom_range(0, 1) ? OP2_ALT : OP2_MAIN;
                    end
                    default:
                    begin
                        w.crn = 4'($urandom);
                        w.crm = $urandom_range(0, 3) ? 4'($urandom_range(0, 1)) : 4'($urandom);
                        w.op2 = 3'($urandom);
                    end
                endcase
            end
            else
            begin
                w.mode = MODE_READ;
                w.crn  = 4'($urandom_range(0, 9));
                w.crm  = (w.crn == CRN_REGION) ? 4'($urandom_range(0, REGION_COUNT + 3)) :
                         ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
                w.op2  = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
                w.op1  = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(1, 7)) : OP1_NONE;
            end
            pending_requests.push_back(w);
        end

        // Reset once, released away from the rising edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: every word taken and every response seen, then a short wait
        // to catch stray responses.
        while ((pending_requests.size() != 0) || req_valid || (expected_responses.size() != 0))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #200_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/scmpu_pkg.sv
rtl/system_coprocessor_with_mpu.sv
rtl/scmpu_checker.sv
sim/tb.sv
